// File: rtl/mur_pkg.sv
package mur_pkg;

    // Default sizing
    localparam int SENSORS_DEF   = 4;
    localparam int TIME_BITS_DEF = 16;

    // Stream widths (bytes-rounded)
    localparam int ECHO_W     = 4;
    localparam int TRIG_W     = 2;
    localparam int MASK_W     = 4;
    localparam int DIST_W     = 11;
    localparam int OUT_DISTS  = 4;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WAIT_W     = 16;
    localparam int TWIDTH_W   = 8;
    localparam int PHASE_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAIT_PERIOD   = 2'd0,
        REG_TRIGGER_WIDTH = 2'd1
    } t_cfg_reg;

    localparam logic [WAIT_W-1:0]   WAIT_RESET  = 16'd60000;
    localparam logic [TWIDTH_W-1:0] TWIDTH_RESET = 8'd10;

    // Distance conversion: span / 58, saturated at 1129.
    // Spans at or above 58 * 1130 saturate; below that span/2 fits 16 bits and
    // (span/2) / 29 is an exact reciprocal multiply for all 16-bit values.
    localparam int CM_DIVISOR  = 58;
    localparam int HALF_DIV    = CM_DIVISOR / 2;
    localparam int DIST_MAX    = 1129;
    localparam int SAT_SPAN    = CM_DIVISOR * (DIST_MAX + 1);
    localparam int SPAN_EXT_W  = 33;
    localparam int HALF_W      = 16;
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = 17;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + HALF_DIV - 1) / HALF_DIV;
    localparam int PROD_W      = HALF_W + RECIP_W;

    // One echo lane's visible state at the output stage
    typedef struct packed {
        logic              upd;
        logic [DIST_W-1:0] range_cm;
    } t_lane_out;

endpackage

// File: rtl/mur_seq.sv
module mur_seq #(
    parameter int TIME_BITS = mur_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mur_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mur_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_accept,
    output logic [mur_pkg::TRIG_W-1:0]     o_trig,
    output logic [TIME_BITS-1:0]           o_now
);

    logic [mur_pkg::WAIT_W-1:0]   r_wait_period;
    logic [mur_pkg::TWIDTH_W-1:0] r_trigger_width;
    logic [TIME_BITS-1:0]         r_time;
    logic                         r_line;
    logic                         r_pulse;
    logic [mur_pkg::PHASE_W-1:0]  r_count;

    logic [mur_pkg::PHASE_W-1:0]  w_wait_len;
    logic [mur_pkg::PHASE_W-1:0]  w_pulse_len;

    // Phase lengths, never zero
    always_comb begin
        w_wait_len  = mur_pkg::PHASE_W'(r_wait_period >> 1);
        w_pulse_len = mur_pkg::PHASE_W'(r_trigger_width);
        if (w_wait_len == '0) begin
            w_wait_len = mur_pkg::PHASE_W'(1);
        end
        if (w_pulse_len == '0) begin
            w_pulse_len = mur_pkg::PHASE_W'(1);
        end
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_period   <= mur_pkg::WAIT_RESET;
            r_trigger_width <= mur_pkg::TWIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == mur_pkg::REG_WAIT_PERIOD) begin
                r_wait_period <= i_cfg_wdata;
            end else if (i_cfg_index == mur_pkg::REG_TRIGGER_WIDTH) begin
                r_trigger_width <= i_cfg_wdata[mur_pkg::TWIDTH_W-1:0];
            end
        end
    end

    // Trigger sequencer and time base, one step per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_line  <= 1'b0;
            r_pulse <= 1'b1;
            r_count <= mur_pkg::PHASE_W'(mur_pkg::TWIDTH_RESET);
        end else if (i_accept) begin
            r_time <= r_time + TIME_BITS'(1);
            if (r_count <= mur_pkg::PHASE_W'(1)) begin
                if (r_pulse) begin
                    r_pulse <= 1'b0;
                    r_count <= w_wait_len;
                end else begin
                    r_line  <= ~r_line;
                    r_pulse <= 1'b1;
                    r_count <= w_pulse_len;
                end
            end else begin
                r_count <= r_count - mur_pkg::PHASE_W'(1);
            end
        end
    end

    assign o_trig = {r_pulse & r_line, r_pulse & ~r_line};
    assign o_now  = r_time;

endmodule

// File: rtl/mur_lane.sv
module mur_lane #(
    parameter int TIME_BITS = mur_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_accept,
    input  logic                 i_echo,
    input  logic [TIME_BITS-1:0] i_now,
    output mur_pkg::t_lane_out   o_lane
);

    localparam int EW = mur_pkg::SPAN_EXT_W;
    localparam int HW = mur_pkg::HALF_W;
    localparam int PW = mur_pkg::PROD_W;
    localparam int DW = mur_pkg::DIST_W;
    localparam int SH = mur_pkg::RECIP_SHIFT;

    logic                 r_prev;
    logic                 r_wait;
    logic [TIME_BITS-1:0] r_rise;

    logic                 r_fall_a;
    logic                 r_sat_a;
    logic [HW-1:0]        r_half_a;

    logic                 r_fall_b;
    logic                 r_sat_b;
    logic [DW-1:0]        r_q_b;

    logic                 r_upd;
    logic [DW-1:0]        r_dist;

    logic                 w_rise;
    logic                 w_fall;
    logic [TIME_BITS-1:0] w_span;
    logic [EW-1:0]        w_ext;
    logic [PW-1:0]        w_prod;

    // Edge detect and pulse length
    assign w_rise = i_echo & ~r_prev & ~r_wait;
    assign w_fall = ~i_echo & r_prev & r_wait;
    assign w_span = i_now - r_rise;
    assign w_ext  = EW'(w_span);

    // Echo tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 1'b0;
            r_wait <= 1'b0;
        end else if (i_accept) begin
            r_prev <= i_echo;
            if (w_rise) begin
                r_wait <= 1'b1;
            end else if (w_fall) begin
                r_wait <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_rise) begin
            r_rise <= i_now;
        end
    end

    // Stage A: saturation check and halved span
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall_a <= 1'b0;
        end else if (i_adv) begin
            r_fall_a <= i_accept & w_fall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sat_a  <= w_ext >= EW'(mur_pkg::SAT_SPAN);
            r_half_a <= w_ext[HW:1];
        end
    end

    // Stage B: reciprocal multiply by 1/29
    assign w_prod = PW'(r_half_a) * PW'(mur_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall_b <= 1'b0;
        end else if (i_adv) begin
            r_fall_b <= r_fall_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sat_b <= r_sat_a;
            r_q_b   <= w_prod[SH+DW-1:SH];
        end
    end

    // Stage C: distance store, shown with the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd  <= 1'b0;
            r_dist <= '0;
        end else if (i_adv) begin
            r_upd <= r_fall_b;
            if (r_fall_b) begin
                r_dist <= r_sat_b ? DW'(mur_pkg::DIST_MAX) : r_q_b;
            end
        end
    end

    assign o_lane.upd      = r_upd;
    assign o_lane.range_cm = r_dist;

endmodule

// File: rtl/multi_ultrasonic_ranger.sv
// Channel   Dir  Handshake              Contents (low bit up)
// s (echo)  in   i_s_tvalid/o_s_tready   [3:0] echo_levels, [7:4] zero
// m (range) out  o_m_tvalid/i_m_tready   [1:0] trigger_levels, [5:2] updated_mask,
//                                        [16:6] d0, [27:17] d1, [38:28] d2, [49:39] d3
// cfg       in   i_cfg_wr_en             index 0 wait_period, 1 trigger_width
//
// One item per cycle sustained while results are taken; an accepted item passes through
// the edge/span stage, reciprocal multiplier stage and distance store stage in turn.
// The whole pipeline advances together whenever the result register is empty
// or being taken, so o_s_tready is low only while a result waits on i_m_tready.
// Synchronous active-low reset clears the sequencer, echo tracking and distances.
module multi_ultrasonic_ranger #(
    parameter int SENSORS   = mur_pkg::SENSORS_DEF,
    parameter int TIME_BITS = mur_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_wr_en,
    input  logic [mur_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mur_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // echo item stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [mur_pkg::IN_DATA_W-1:0]  i_s_tdata,  // [3:0] echo_levels
    // result item stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mur_pkg::OUT_DATA_W-1:0] o_m_tdata   // trigger_levels, updated_mask,
                                                       // distance_zero..distance_three
);

    localparam int DW = mur_pkg::DIST_W;

    logic                          w_adv;
    logic                          w_accept;
    logic [mur_pkg::TRIG_W-1:0]    w_trig;
    logic [TIME_BITS-1:0]          w_now;
    mur_pkg::t_lane_out            w_lane [SENSORS];

    logic                          r_v_a;
    logic                          r_v_b;
    logic                          r_v_c;
    logic [mur_pkg::TRIG_W-1:0]    r_trig_a;
    logic [mur_pkg::TRIG_W-1:0]    r_trig_b;
    logic [mur_pkg::TRIG_W-1:0]    r_trig_c;

    logic [mur_pkg::MASK_W-1:0]    w_mask;
    logic [DW-1:0]                 w_dist [mur_pkg::OUT_DISTS];

    // Pipeline advance
    assign w_adv      = ~r_v_c | i_m_tready;
    assign w_accept   = i_s_tvalid & w_adv;
    assign o_s_tready = w_adv;

    mur_seq #(
        .TIME_BITS(TIME_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .o_trig      (w_trig),
        .o_now       (w_now)
    );

    // Echo lanes; sensors past the echo bits see a constant low level
    for (genvar g = 0; g < SENSORS; g++) begin : g_lane
        logic w_echo;
        if (g < mur_pkg::ECHO_W) begin : g_pin
            assign w_echo = i_s_tdata[g];
        end else begin : g_nopin
            assign w_echo = 1'b0;
        end
        mur_lane #(
            .TIME_BITS(TIME_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_accept (w_accept),
            .i_echo   (w_echo),
            .i_now    (w_now),
            .o_lane   (w_lane[g])
        );
    end

    // Valid and trigger alignment with the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
        end else if (w_adv) begin
            r_v_a <= w_accept;
            r_v_b <= r_v_a;
            r_v_c <= r_v_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_trig_a <= w_trig;
            r_trig_b <= r_trig_a;
            r_trig_c <= r_trig_b;
        end
    end

    // Merge lane results; missing sensors read as zero
    for (genvar k = 0; k < mur_pkg::OUT_DISTS; k++) begin : g_merge
        if (k < SENSORS) begin : g_have
            assign w_mask[k] = w_lane[k].upd;
            assign w_dist[k] = w_lane[k].range_cm;
        end else begin : g_none
            assign w_mask[k] = 1'b0;
            assign w_dist[k] = '0;
        end
    end

    assign o_m_tvalid = r_v_c;
    assign o_m_tdata  = {6'd0, w_dist[3], w_dist[2], w_dist[1], w_dist[0], w_mask, r_trig_c};

endmodule

// File: dv/echo_range_checker.sv
module echo_range_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mur_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mur_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [mur_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [3:0] echo_levels
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [mur_pkg::OUT_DATA_W-1:0] i_m_tdata,   // trigger_levels, updated_mask,
                                                        // distances 0..3
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_W    = mur_pkg::TIME_BITS_DEF;
    localparam int ECHO_W    = mur_pkg::ECHO_W;
    localparam int OUT_DISTS = mur_pkg::OUT_DISTS;
    localparam int DIST_W    = mur_pkg::DIST_W;
    localparam int TRIG_W    = mur_pkg::TRIG_W;
    localparam int PHASE_W   = mur_pkg::PHASE_W;

    // Result item layout, lowest bits last
    typedef struct packed {
        logic [OUT_DISTS-1:0][DIST_W-1:0] ranges;
        logic [mur_pkg::MASK_W-1:0]       upd;
        logic [TRIG_W-1:0]                trig;
    } t_range_item;

    // Shadow registers
    logic [mur_pkg::WAIT_W-1:0]   wait_reg;
    logic [mur_pkg::TWIDTH_W-1:0] width_reg;

    // Shadow sequencer and echo tracking
    logic [TICK_W-1:0]  tick_now;
    logic               line_sel;
    logic               pulse_on;
    logic [PHASE_W-1:0] phase_left;
    logic [ECHO_W-1:0]  armed;
    logic [ECHO_W-1:0]  last_lvl;
    logic [TICK_W-1:0]  rise_at  [ECHO_W];
    logic [DIST_W-1:0]  range_cm [OUT_DISTS];

    t_range_item ranges_q[$];
    int          n_seen;

    // a zero-length phase still lasts one tick
    function automatic logic [PHASE_W-1:0] phase_ticks(input int unsigned v);
        return (v == 0) ? PHASE_W'(1) : PHASE_W'(v);
    endfunction

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        o_fail_count++;
    endtask

    // One microsecond tick: echo edges, then the trigger sequencer
    task automatic range_tick(input logic [ECHO_W-1:0] lvl, output t_range_item r);
        logic [TICK_W-1:0] span;
        int unsigned       cm;
        r.trig = pulse_on ? (TRIG_W'(1) << line_sel) : '0;
        r.upd  = '0;
        for (int i = 0; i < ECHO_W; i++) begin
            if (lvl[i] && !last_lvl[i] && !armed[i]) begin
                rise_at[i] = tick_now;
                armed[i]   = 1'b1;
            end else if (!lvl[i] && last_lvl[i] && armed[i]) begin
                span = tick_now - rise_at[i];
                cm   = span / mur_pkg::CM_DIVISOR;
                if (cm > mur_pkg::DIST_MAX) cm = mur_pkg::DIST_MAX;
                range_cm[i] = cm[DIST_W-1:0];
                r.upd[i]    = 1'b1;
                armed[i]    = 1'b0;
            end
        end
        last_lvl = lvl;

        if (phase_left <= 1) begin
            if (pulse_on) begin
                pulse_on   = 1'b0;
                phase_left = phase_ticks(wait_reg >> 1);
            end else begin
                line_sel   = ~line_sel;
                pulse_on   = 1'b1;
                phase_left = phase_ticks(width_reg);
            end
        end else begin
            phase_left--;
        end
        tick_now++;

        for (int i = 0; i < OUT_DISTS; i++) r.ranges[i] = range_cm[i];
    endtask

    always @(posedge i_clk) begin : watch
        t_range_item got;
        t_range_item want;
        if (!i_rst_n) begin
            wait_reg   = mur_pkg::WAIT_RESET;
            width_reg  = mur_pkg::TWIDTH_RESET;
            tick_now   = '0;
            line_sel   = 1'b0;
            pulse_on   = 1'b1;
            phase_left = PHASE_W'(mur_pkg::TWIDTH_RESET);
            armed      = '0;
            last_lvl   = '0;
            for (int i = 0; i < ECHO_W; i++) rise_at[i] = '0;
            for (int i = 0; i < OUT_DISTS; i++) range_cm[i] = '0;
            ranges_q.delete();
            n_seen = 0;
        end else begin
            // register writes; unknown indexes are dropped
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mur_pkg::REG_WAIT_PERIOD:
                        wait_reg  = i_cfg_wdata[mur_pkg::WAIT_W-1:0];
                    mur_pkg::REG_TRIGGER_WIDTH:
                        width_reg = i_cfg_wdata[mur_pkg::TWIDTH_W-1:0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                range_tick(i_s_tdata[ECHO_W-1:0], want);
                ranges_q.push_back(want);
            end

            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_range_item)-1:0];
                if (ranges_q.size() == 0) begin
                    report($sformatf("result %0d arrived with no item outstanding", n_seen));
                end else begin
                    want = ranges_q.pop_front();
                    if (got.trig !== want.trig)
                        report($sformatf("result %0d trigger_levels got %0d expected %0d",
                                         n_seen, got.trig, want.trig));
                    if (got.upd !== want.upd)
                        report($sformatf("result %0d updated_mask got %0d expected %0d",
                                         n_seen, got.upd, want.upd));
                    for (int i = 0; i < OUT_DISTS; i++)
                        if (got.ranges[i] !== want.ranges[i])
                            report($sformatf("result %0d distance %0d got %0d expected %0d",
                                             n_seen, i, got.ranges[i], want.ranges[i]));
                end
                n_seen++;
            end
        end
        o_pending = ranges_q.size();
    end

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 1;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_IDLE     = 18;
    localparam int SETTLE       = 6;   // pipeline is three deep
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int FAST_ITEMS   = 140;
    localparam int LONG_TICKS   = 160;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 80;

    localparam int CFG_IDX_W  = mur_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mur_pkg::CFG_DATA_W;
    localparam int ECHO_W     = mur_pkg::ECHO_W;
    localparam int IN_DATA_W  = mur_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = mur_pkg::OUT_DATA_W;

    // indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // edge patterns: all rise at once, staggered rise and fall, alternating pairs
    localparam logic [ECHO_W-1:0] DIRECTED_ECHO [18] = '{
        4'hF, 4'hF, 4'h0, 4'h1, 4'h3, 4'h7, 4'hF, 4'hE, 4'hC,
        4'h8, 4'h0, 4'h5, 4'hA, 4'h5, 4'hA, 4'h0, 4'hF, 4'h0
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    pending;

    bit                    idle_on;
    logic [ECHO_W-1:0]     echo_lvl;
    int                    pulse_left [ECHO_W];

    always #CLK_HALF clk = ~clk;

    multi_ultrasonic_ranger u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    echo_range_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int idle_draw();
        if (!idle_on) return 0;
        return $urandom_range(0, 1) ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    // Present one tick of echo levels; returns at the falling edge after accept
    task automatic send_echo(input logic [ECHO_W-1:0] lvl);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= IN_DATA_W'(lvl);
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // Drain all results, optionally write a spare index, then rewrite both registers
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] wait_val,
                               input logic [CFG_DATA_W-1:0] width_val);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if ($urandom_range(0, 1))
            write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
        write_cfg(mur_pkg::REG_WAIT_PERIOD, wait_val);
        write_cfg(mur_pkg::REG_TRIGGER_WIDTH, width_val);
        cfg_wr_en <= 1'b0;
    endtask

    // Echo pulses of random length per sensor, with some noise items mixed in
    task automatic draw_echo(output logic [ECHO_W-1:0] lvl);
        if ($urandom_range(0, 9) == 0) begin
            lvl = ECHO_W'($urandom);
        end else begin
            for (int i = 0; i < ECHO_W; i++) begin
                if (pulse_left[i] == 0) begin
                    echo_lvl[i] = ~echo_lvl[i];
                    if (echo_lvl[i])
                        pulse_left[i] = ($urandom_range(0, 3) == 0) ?
                                        $urandom_range(58, 400) : $urandom_range(1, 120);
                    else
                        pulse_left[i] = $urandom_range(1, 25);
                end
                pulse_left[i]--;
            end
            lvl = echo_lvl;
        end
    endtask

    // Result sink with random stalls
    initial begin : sink
        int stall;
        m_tready = 1'b0;
        @(negedge clk);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        logic [ECHO_W-1:0]     lvl;
        logic [CFG_DATA_W-1:0] wait_val;
        logic [CFG_DATA_W-1:0] width_val;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        idle_on   = 1'b1;
        echo_lvl  = '0;
        for (int i = 0; i < ECHO_W; i++) pulse_left[i] = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, directed edge patterns
        foreach (DIRECTED_ECHO[k]) send_echo(DIRECTED_ECHO[k]);

        // zero-length phases; width data has high bits set above the register
        reconfigure(16'h0000, 16'hAB00);
        repeat (60) begin
            draw_echo(lvl);
            send_echo(lvl);
        end

        // shortest wait, widest pulse, no idling
        reconfigure(16'h0001, 16'h54FF);
        idle_on = 1'b0;
        repeat (FAST_ITEMS) begin
            draw_echo(lvl);
            send_echo(lvl);
        end

        // long overlapping pulses of different lengths on every sensor
        reconfigure(16'hFFFF, 16'h00FF);
        for (int t = 0; t < LONG_TICKS; t++) begin
            lvl[0] = (t >= 1) && (t <= 150);
            lvl[1] = (t >= 1) && (t <= 120);
            lvl[2] = 1'((t / 30) % 2);
            lvl[3] = (t >= 1) && (t < 100);
            send_echo(lvl);
        end

        // random settings and idling per phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: begin
                    wait_val  = CFG_DATA_W'($urandom);
                    width_val = CFG_DATA_W'($urandom);
                end
                1: begin
                    wait_val  = 16'd2;
                    width_val = 16'd1;
                end
                default: begin
                    wait_val  = CFG_DATA_W'($urandom_range(2, 40));
                    width_val = CFG_DATA_W'($urandom_range(1, 8));
                end
            endcase
            reconfigure(wait_val, width_val);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) begin
                draw_echo(lvl);
                send_echo(lvl);
            end
        end

        // drain and give the verdict
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/mur_pkg.sv
rtl/mur_seq.sv
rtl/mur_lane.sv
rtl/multi_ultrasonic_ranger.sv
dv/echo_range_checker.sv
dv/testbench.sv
